FILE: sv/adsr_pkg.sv
// adsr_pkg: constants, payload types and register codes for the adsr gain envelope
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package adsr_pkg;

	localparam int MAX_LEN     = 1048576;
	localparam int SAMPLE_BITS = 24;

	localparam int LEN_W     = $clog2(MAX_LEN) + 1;
	localparam int IDX_W     = LEN_W;
	localparam int GAIN_W    = 24;
	localparam int GAIN_FRAC = 23;
	localparam int SAMPLE_W  = SAMPLE_BITS;
	localparam int PHASE_W   = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = GAIN_W;

	localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1) << GAIN_FRAC;
	localparam logic [IDX_W-1:0]  INDEX_MAX  = '1;

	localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd2;
	localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd3;
	localparam logic [PHASE_W-1:0] PH_PAST    = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_LEN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP  = 3'd7;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_in;
		logic                       restart;
	} in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic [PHASE_W-1:0]         phase;
		logic                       pass_end;
	} out_t;

	typedef struct packed {
		logic [LEN_W-1:0]  sample_count;
		logic [LEN_W-1:0]  attack_len;
		logic [LEN_W-1:0]  decay_len;
		logic [LEN_W-1:0]  release_len;
		logic [GAIN_W-1:0] sustain_level;
		logic [GAIN_W-1:0] attack_step;
		logic [GAIN_W-1:0] decay_step;
		logic [GAIN_W-1:0] release_step;
	} cfg_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  gain;
		logic [PHASE_W-1:0] phase;
		logic               pass_end;
		logic [IDX_W-1:0]   next_idx;
	} env_t;

endpackage

FILE: sv/adsr_env_step.sv
// adsr_env_step: phase selection and gain update for one sample
// depends on adsr_pkg
`timescale 1ns / 1ps

module adsr_env_step (
	input  adsr_pkg::cfg_t                    cfg,
	input  logic [adsr_pkg::IDX_W-1:0]        idx_cur,
	input  logic [adsr_pkg::GAIN_W-1:0]       gain_cur,
	input  logic                              restart,
	output adsr_pkg::env_t                    env
);
	import adsr_pkg::*;

	logic [IDX_W-1:0]  idx;
	logic [LEN_W-1:0]  rel_start;
	logic [LEN_W:0]    ad_end;
	logic [GAIN_W:0]   att_sum;
	logic [GAIN_W-1:0] rel_base;
	logic [GAIN_W-1:0] att_gain;
	logic [GAIN_W-1:0] dec_gain;
	logic [GAIN_W-1:0] rel_gain;

	always_comb begin
		idx       = restart ? '0 : idx_cur;
		rel_start = (cfg.sample_count > cfg.release_len) ?
			cfg.sample_count - cfg.release_len : '0;
		ad_end    = {1'b0, cfg.attack_len} + {1'b0, cfg.decay_len};
		att_sum   = {1'b0, gain_cur} + {1'b0, cfg.attack_step};
		att_gain  = (att_sum > {1'b0, UNITY_GAIN}) ? UNITY_GAIN : att_sum[GAIN_W-1:0];
		dec_gain  = (gain_cur > cfg.decay_step) ? gain_cur - cfg.decay_step : '0;
		rel_base  = (idx == rel_start) ? cfg.sustain_level : gain_cur;
		rel_gain  = (rel_base > cfg.release_step) ? rel_base - cfg.release_step : '0;

		priority if (idx >= cfg.sample_count) begin
			env.phase = PH_PAST;
			env.gain  = '0;
		end else if (idx >= rel_start) begin
			env.phase = PH_RELEASE;
			env.gain  = rel_gain;
		end else if (idx < cfg.attack_len) begin
			env.phase = PH_ATTACK;
			env.gain  = (idx == '0) ? '0 : att_gain;
		end else if ({1'b0, idx} < ad_end) begin
			env.phase = PH_DECAY;
			env.gain  = (idx == cfg.attack_len) ? UNITY_GAIN : dec_gain;
		end else begin
			env.phase = PH_SUSTAIN;
			env.gain  = cfg.sustain_level;
		end

		env.pass_end = (({1'b0, idx} + (LEN_W + 1)'(1)) == {1'b0, cfg.sample_count});
		env.next_idx = (idx != INDEX_MAX) ? idx + IDX_W'(1) : idx;
	end

endmodule

FILE: sv/adsr_scale.sv
// adsr_scale: sample times gain, floor shift by the gain fraction, saturation
// and zero output past the end; depends on adsr_pkg
`timescale 1ns / 1ps

module adsr_scale (
	input  logic signed [adsr_pkg::SAMPLE_W-1:0] sample,
	input  logic [adsr_pkg::GAIN_W-1:0]          gain,
	input  logic                                 past_end,
	output logic signed [adsr_pkg::SAMPLE_W-1:0] scaled
);
	import adsr_pkg::*;

	localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
	localparam int SH_W   = PROD_W - GAIN_FRAC;

	logic signed [PROD_W-1:0] prod;
	logic signed [SH_W-1:0]   shifted;
	logic                     in_range;

	always_comb begin
		prod     = PROD_W'(sample) * PROD_W'($signed({1'b0, gain}));
		shifted  = prod[PROD_W-1:GAIN_FRAC];
		in_range = (shifted[SH_W-1:SAMPLE_W-1] == '0) || (shifted[SH_W-1:SAMPLE_W-1] == '1);
		if (past_end) begin
			scaled = '0;
		end else if (in_range) begin
			scaled = shifted[SAMPLE_W-1:0];
		end else if (shifted[SH_W-1]) begin
			scaled = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			scaled = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

endmodule

FILE: sv/adsr_gain_envelope.sv
// adsr_gain_envelope: top level, configuration registers, envelope state and pipeline
// depends on adsr_pkg, adsr_env_step, adsr_scale
`timescale 1ns / 1ps

// usage
// - input channel in_valid / in_stall / in_data carries one sample word with a
//   restart flag; restart sends the pass back to index zero for that sample
// - output channel out_valid / out_stall / out_data returns one word per input
//   word, in order: scaled sample, phase code and end-of-pass flag
// - configuration channel cfg_valid / cfg_ready / cfg_index / cfg_data writes
//   one of eight registers; cfg_ready is always high; write only while idle
// - an accepted input word is registered in stage 1, then in the output word register
// - throughput is one word per cycle while the output is not stalled; the gain update
//   loops through the envelope state registers only, the multiply sits in the following stage
// - when the receiver stalls, the output word holds and the middle stage still
//   takes one more word if it is empty; in_stall rises once it holds a word
// - reset clears the sample index and gain, empties the pipeline and loads the
//   register defaults: lengths 1, sustain and attack step unity, other steps 0

module adsr_gain_envelope (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  adsr_pkg::in_t                      in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output adsr_pkg::out_t                     out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [adsr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [adsr_pkg::CFG_W-1:0]         cfg_data
);
	import adsr_pkg::*;

	cfg_t              cfg_q;
	logic [IDX_W-1:0]  idx_q;
	logic [GAIN_W-1:0] gain_q;

	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic [GAIN_W-1:0]          gain_s1;
	logic [PHASE_W-1:0]         phase_s1;
	logic                       pass_end_s1;

	logic                       out_valid_q;
	out_t                       out_q;

	env_t                       env;
	logic signed [SAMPLE_W-1:0] scaled;
	logic                       s2_free;
	logic                       s1_free;
	logic                       in_take;

	assign s2_free   = !out_valid_q || !out_stall;
	assign s1_free   = !valid_s1 || s2_free;
	assign in_stall  = !s1_free;
	assign in_take   = in_valid && s1_free;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_count  <= LEN_W'(1);
			cfg_q.attack_len    <= LEN_W'(1);
			cfg_q.decay_len     <= LEN_W'(1);
			cfg_q.release_len   <= LEN_W'(1);
			cfg_q.sustain_level <= UNITY_GAIN;
			cfg_q.attack_step   <= UNITY_GAIN;
			cfg_q.decay_step    <= '0;
			cfg_q.release_step  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SAMPLE_COUNT:  cfg_q.sample_count  <= cfg_data[LEN_W-1:0];
				REG_ATTACK_LEN:    cfg_q.attack_len    <= cfg_data[LEN_W-1:0];
				REG_DECAY_LEN:     cfg_q.decay_len     <= cfg_data[LEN_W-1:0];
				REG_RELEASE_LEN:   cfg_q.release_len   <= cfg_data[LEN_W-1:0];
				REG_SUSTAIN_LEVEL: cfg_q.sustain_level <= cfg_data[GAIN_W-1:0];
				REG_ATTACK_STEP:   cfg_q.attack_step   <= cfg_data[GAIN_W-1:0];
				REG_DECAY_STEP:    cfg_q.decay_step    <= cfg_data[GAIN_W-1:0];
				REG_RELEASE_STEP:  cfg_q.release_step  <= cfg_data[GAIN_W-1:0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	adsr_env_step u_step (
		.cfg      (cfg_q),
		.idx_cur  (idx_q),
		.gain_cur (gain_q),
		.restart  (in_data.restart),
		.env      (env)
	);

	// envelope state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			gain_q <= '0;
		end else if (in_take) begin
			idx_q  <= env.next_idx;
			gain_q <= env.gain;
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_s1   <= in_data.sample_in;
			gain_s1     <= env.gain;
			phase_s1    <= env.phase;
			pass_end_s1 <= env.pass_end;
		end
	end

	adsr_scale u_scale (
		.sample   (sample_s1),
		.gain     (gain_s1),
		.past_end (phase_s1 == PH_PAST),
		.scaled   (scaled)
	);

	// output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			out_q.sample_out <= scaled;
			out_q.phase      <= phase_s1;
			out_q.pass_end   <= pass_end_s1;
		end
	end

endmodule
